/* rtl/core/rau_pkg.sv */
// rau_pkg: shared types and codes of the rational arithmetic unit.
// Holds the operand and result transaction structs, operation and status codes
// and the sequencer state type. Depends on nothing.
package rau_pkg;

	// Operation codes (a op b)
	localparam logic [1:0] FUNC_ADD = 2'd0;
	localparam logic [1:0] FUNC_SUB = 2'd1;
	localparam logic [1:0] FUNC_MUL = 2'd2;
	localparam logic [1:0] FUNC_DIV = 2'd3;

	// Status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_ZERO_DEN = 2'd1;
	localparam logic [1:0] STAT_OVERFLOW = 2'd2;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] a_numerator;
		logic signed [31:0] a_denominator;
		logic signed [31:0] b_numerator;
		logic signed [31:0] b_denominator;
	} rau_in_t;

	typedef struct packed {
		logic signed [31:0] result_numerator;
		logic [30:0]        result_denominator;
		logic [1:0]         status;
	} rau_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_NORM,
		ST_GCD,
		ST_DIVN,
		ST_DIVD,
		ST_PACK,
		ST_FIN
	} rau_state_t;

endpackage

/* rtl/core/rational_arithmetic_unit.sv */
// rational_arithmetic_unit: exact fraction add, subtract, multiply and divide
// with reduction to lowest terms by a binary gcd and two serial divisions.
// Depends on rau_pkg.
//
//   channel   | handshake            | payload
//   ----------+----------------------+-------------------------------------
//   operands  | start in, busy out   | rau_in_t: func, a and b fractions
//   result    | done out (strobe)    | rau_out_t: reduced fraction, status
//
// A transaction is taken at a rising edge with start high and busy low; busy
// then stays high until the result has been shown. The result sits on the
// result port for the single cycle in which done is high; the receiver
// cannot stall it. Add and subtract also form a third product and a signed
// sum; the gcd runs by binary steps and the two bit-serial divisions run
// through the shared compare/subtract unit. Operand errors show their result
// in the cycle right after the accept; a zero result skips the gcd and both
// divisions. Reset clears the sequencer only; there is no memory to clear.
module rational_arithmetic_unit #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  rau_pkg::rau_in_t operands,
	output logic             done,
	output rau_pkg::rau_out_t result
);
	import rau_pkg::*;

	localparam int VW = VALUE_WIDTH;
	localparam int W2 = 2 * VW;      // full-width product magnitude
	localparam int UW = W2 + 1;      // shared unit width (division shift-in)
	localparam int CW = $clog2(W2);  // step counter and common-twos count
	localparam logic [W2-1:0] HALF = W2'(1) << (VW - 1);

	function automatic logic [VW-1:0] mag_of(input logic [VW-1:0] v);
		logic [VW-1:0] r;
		r = v[VW-1] ? (~v + VW'(1)) : v;
		return r;
	endfunction

	// Sequencer
	rau_state_t state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] k_q, k_d;

	// Operand magnitudes and term signs
	logic [1:0]    func_q;
	logic [VW-1:0] an_q, ad_q, bn_q, bd_q;
	logic          s_p0_q, s_p2_q, s_den_q;

	// Products, gcd working pair, divider
	logic [W2-1:0] num_q, den_q, prod_q;
	logic [W2-1:0] gx_q, gy_q;
	logic [W2-1:0] rem_q, quo_q, n_q;
	rau_out_t      result_q;

	// Input decode
	logic [VW-1:0] in_an, in_ad, in_bn, in_bd;
	logic          in_err, accept;

	assign in_an  = operands.a_numerator[VW-1:0];
	assign in_ad  = operands.a_denominator[VW-1:0];
	assign in_bn  = operands.b_numerator[VW-1:0];
	assign in_bd  = operands.b_denominator[VW-1:0];
	assign in_err = (in_ad == '0) || (in_bd == '0)
		|| ((operands.func == FUNC_DIV) && (in_bn == '0));
	assign accept = start && !busy;

	// Shared multiplier: one product per cycle
	logic [VW-1:0] mul_a, mul_b;
	logic [W2-1:0] mul_p;

	always_comb begin
		case (cnt_q)
			CW'(0): begin
				mul_a = an_q;
				mul_b = (func_q == FUNC_MUL) ? bn_q : bd_q;
			end
			CW'(1): begin
				mul_a = ad_q;
				mul_b = (func_q == FUNC_DIV) ? bn_q : bd_q;
			end
			default: begin
				mul_a = bn_q;
				mul_b = ad_q;
			end
		endcase
		mul_p = W2'(mul_a) * W2'(mul_b);
	end

	// Shared compare / add / subtract unit
	logic [UW-1:0] ux, uy, u_big, u_small, ures;
	logic          uadd, uge;
	logic [UW-1:0] div_t;

	assign div_t = {rem_q, quo_q[W2-1]};

	always_comb begin
		case (state_q)
			ST_ADD: begin
				ux   = UW'(num_q);
				uy   = UW'(prod_q);
				uadd = (s_p0_q == s_p2_q);
			end
			ST_GCD: begin
				ux   = UW'(gx_q);
				uy   = UW'(gy_q);
				uadd = 1'b0;
			end
			ST_DIVN, ST_DIVD: begin
				ux   = div_t;
				uy   = UW'(gx_q);
				uadd = 1'b0;
			end
			default: begin
				ux   = '0;
				uy   = '0;
				uadd = 1'b0;
			end
		endcase
		uge     = (ux >= uy);
		u_big   = uge ? ux : uy;
		u_small = uge ? uy : ux;
		ures    = uadd ? (ux + uy) : (u_big - u_small);
	end

	logic mul_addsub, mul_last, div_last, both_odd, gcd_done;

	assign mul_addsub = (func_q == FUNC_ADD) || (func_q == FUNC_SUB);
	assign mul_last   = (cnt_q == (mul_addsub ? CW'(2) : CW'(1)));
	assign div_last   = (cnt_q == CW'(W2 - 1));
	assign both_odd   = gx_q[0] && gy_q[0];
	assign gcd_done   = both_odd && (ures == '0);

	// Next state and counters
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		k_d     = k_q;
		unique case (state_q)
			ST_IDLE: begin
				cnt_d = '0;
				if (start)
					state_d = in_err ? ST_FIN : ST_MUL;
			end
			ST_MUL: begin
				if (mul_last) begin
					cnt_d   = '0;
					state_d = mul_addsub ? ST_ADD : ST_NORM;
				end else begin
					cnt_d = cnt_q + CW'(1);
				end
			end
			ST_ADD: state_d = ST_NORM;
			ST_NORM: begin
				k_d     = '0;
				state_d = (num_q == '0) ? ST_FIN : ST_GCD;
			end
			ST_GCD: begin
				cnt_d = '0;
				if (!gx_q[0] && !gy_q[0])
					k_d = k_q + CW'(1);
				if (gcd_done)
					state_d = ST_DIVN;
			end
			ST_DIVN: begin
				cnt_d = cnt_q + CW'(1);
				if (div_last)
					state_d = ST_DIVD;
			end
			ST_DIVD: begin
				cnt_d = cnt_q + CW'(1);
				if (div_last)
					state_d = ST_PACK;
			end
			ST_PACK: state_d = ST_FIN;
			ST_FIN:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			k_q     <= k_d;
		end
	end

	// Final packing: range check and sign restore
	logic          neg;
	logic          fits;
	logic [W2-1:0] n_signed;
	logic signed [VW-1:0] n_out;

	assign neg      = s_p0_q ^ s_den_q;
	assign fits     = (neg ? (n_q <= HALF) : (n_q < HALF)) && (quo_q < HALF);
	assign n_signed = neg ? (~n_q + W2'(1)) : n_q;
	assign n_out    = n_signed[VW-1:0];

	// Datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					func_q  <= operands.func;
					an_q    <= mag_of(in_an);
					ad_q    <= mag_of(in_ad);
					bn_q    <= mag_of(in_bn);
					bd_q    <= mag_of(in_bd);
					// signs of the two numerator terms and of the denominator
					s_p0_q  <= in_an[VW-1] ^ ((operands.func == FUNC_MUL) ?
						in_bn[VW-1] : in_bd[VW-1]);
					s_p2_q  <= in_bn[VW-1] ^ in_ad[VW-1] ^ (operands.func == FUNC_SUB);
					s_den_q <= in_ad[VW-1] ^ ((operands.func == FUNC_DIV) ?
						in_bn[VW-1] : in_bd[VW-1]);
					result_q.result_numerator   <= '0;
					result_q.result_denominator <= '0;
					result_q.status             <= STAT_ZERO_DEN;
				end
			end
			ST_MUL: begin
				case (cnt_q)
					CW'(0):  num_q  <= mul_p;
					CW'(1):  den_q  <= mul_p;
					default: prod_q <= mul_p;
				endcase
			end
			ST_ADD: begin
				// sign-magnitude sum of the two cross products
				num_q  <= ures[W2-1:0];
				s_p0_q <= uadd ? s_p0_q : (uge ? s_p0_q : s_p2_q);
			end
			ST_NORM: begin
				gx_q <= num_q;
				gy_q <= den_q;
				result_q.result_numerator   <= '0;
				result_q.result_denominator <= 31'd1;
				result_q.status             <= STAT_OK;
			end
			ST_GCD: begin
				if (!gx_q[0] && !gy_q[0]) begin
					gx_q <= gx_q >> 1;
					gy_q <= gy_q >> 1;
				end else if (!gx_q[0]) begin
					gx_q <= gx_q >> 1;
				end else if (!gy_q[0]) begin
					gy_q <= gy_q >> 1;
				end else if (gcd_done) begin
					// hold gx: it is the odd part of the gcd and the divisor
				end else if (uge) begin
					gx_q <= ures[W2:1];
				end else begin
					gy_q <= ures[W2:1];
				end
				// gcd = gx_q << k_q: drop the common twos from the dividend
				quo_q <= num_q >> k_q;
				rem_q <= '0;
			end
			ST_DIVN: begin
				if (div_last) begin
					n_q   <= {quo_q[W2-2:0], uge};
					quo_q <= den_q >> k_q;
					rem_q <= '0;
				end else begin
					quo_q <= {quo_q[W2-2:0], uge};
					rem_q <= uge ? ures[W2-1:0] : div_t[W2-1:0];
				end
			end
			ST_DIVD: begin
				quo_q <= {quo_q[W2-2:0], uge};
				rem_q <= uge ? ures[W2-1:0] : div_t[W2-1:0];
			end
			ST_PACK: begin
				if (fits) begin
					result_q.result_numerator   <= 32'(n_out);
					result_q.result_denominator <= 31'(quo_q[VW-2:0]);
					result_q.status             <= STAT_OK;
				end else begin
					result_q.result_numerator   <= '0;
					result_q.result_denominator <= '0;
					result_q.status             <= STAT_OVERFLOW;
				end
			end
			ST_FIN: ;
			default: ;
		endcase
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = (state_q == ST_FIN);
	assign result = result_q;

	// Checks
	a_ok_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == STAT_OK) |-> result.result_denominator != '0)
		else $error("ok result with zero denominator");

	a_err_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status != STAT_OK) |->
			(result.result_numerator == '0) && (result.result_denominator == '0))
		else $error("error result with nonzero fields");

	a_gcd_operands_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GCD) |-> (gx_q != '0) && (gy_q != '0))
		else $error("gcd working value reached zero");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accept");

	a_done_releases: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("busy held after result");

endmodule

/* test/rau_fraction_checker.sv */
// rau_fraction_checker: watches the operand and result channels of the rational
// arithmetic unit, predicts each reduced fraction and compares it field by field.
// Depends on rau_pkg.
module rau_fraction_checker #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  rau_pkg::rau_in_t  operands,
	input  logic              done,
	input  rau_pkg::rau_out_t result,
	output int                mismatches,
	output int                outstanding
);
	import rau_pkg::*;

	localparam logic [63:0] WIDTH_MASK = (64'd1 << VALUE_WIDTH) - 64'd1;
	localparam logic [63:0] HALF_RANGE = 64'd1 << (VALUE_WIDTH - 1);
	localparam int REPORT_LIMIT = 40;

	typedef struct packed {
		logic        neg;
		logic [63:0] mag;
	} sign_mag_t;

	rau_out_t expected_fractions[$];
	int fail_count = 0;
	int queued = 0;

	assign mismatches = fail_count;
	assign outstanding = queued;

	function automatic sign_mag_t split_sign(logic [31:0] raw);
		sign_mag_t r;
		logic [63:0] v;
		v = {32'd0, raw} & WIDTH_MASK;
		r.neg = v[VALUE_WIDTH-1];
		r.mag = r.neg ? (WIDTH_MASK + 64'd1 - v) : v;
		return r;
	endfunction

	function automatic sign_mag_t multiply(sign_mag_t x, sign_mag_t y);
		sign_mag_t r;
		r.mag = x.mag * y.mag;
		r.neg = (x.neg != y.neg) && (r.mag != 64'd0);
		return r;
	endfunction

	function automatic rau_out_t reduce_fraction(rau_in_t op);
		sign_mag_t an, ad, bn, bd, p, q, num, den;
		logic [63:0] x, y, t, n, d;
		logic neg, fits;
		rau_out_t r;
		an = split_sign(op.a_numerator);
		ad = split_sign(op.a_denominator);
		bn = split_sign(op.b_numerator);
		bd = split_sign(op.b_denominator);
		r = '0;
		r.status = STAT_ZERO_DEN;
		if (ad.mag == 0 || bd.mag == 0 || (op.func == FUNC_DIV && bn.mag == 0))
			return r;
		case (op.func)
			FUNC_ADD, FUNC_SUB: begin
				if (op.func == FUNC_SUB)
					bn.neg = !bn.neg && (bn.mag != 0);
				p = multiply(an, bd);
				q = multiply(bn, ad);
				if (p.neg == q.neg) begin
					num.mag = p.mag + q.mag;
					num.neg = p.neg;
				end else if (p.mag >= q.mag) begin
					num.mag = p.mag - q.mag;
					num.neg = p.neg;
				end else begin
					num.mag = q.mag - p.mag;
					num.neg = q.neg;
				end
				den = multiply(ad, bd);
			end
			FUNC_MUL: begin
				num = multiply(an, bn);
				den = multiply(ad, bd);
			end
			default: begin
				num = multiply(an, bd);
				den = multiply(ad, bn);
			end
		endcase
		// zero always comes out as 0/1, whatever the signs
		if (num.mag == 0) begin
			r.result_denominator = 31'd1;
			r.status = STAT_OK;
			return r;
		end
		x = num.mag;
		y = den.mag;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		n = num.mag / x;
		d = den.mag / x;
		neg = num.neg != den.neg;
		fits = (neg ? (n <= HALF_RANGE) : (n < HALF_RANGE)) && (d < HALF_RANGE);
		if (!fits) begin
			r.status = STAT_OVERFLOW;
			return r;
		end
		r.result_numerator = neg ? -n[31:0] : n[31:0];
		r.result_denominator = d[30:0];
		r.status = STAT_OK;
		return r;
	endfunction

	task automatic report(string field, logic signed [63:0] want, logic signed [63:0] got);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
	endtask

	always @(posedge clk) begin
		rau_out_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_fractions.size() == 0) begin
					report("unexpected result, numerator", 0, result.result_numerator);
				end else begin
					want = expected_fractions.pop_front();
					if (result.result_numerator !== want.result_numerator)
						report("result_numerator", want.result_numerator,
							result.result_numerator);
					if (result.result_denominator !== want.result_denominator)
						report("result_denominator", {1'b0, want.result_denominator},
							{1'b0, result.result_denominator});
					if (result.status !== want.status)
						report("status", want.status, result.status);
				end
			end
			if (start && !busy)
				expected_fractions.push_back(reduce_fraction(operands));
			queued <= expected_fractions.size();
		end
	end

endmodule

/* test/rational_arithmetic_unit_tb.sv */
// rational_arithmetic_unit_tb: drives operand transactions into the rational
// arithmetic unit and gives the verdict. Depends on rau_pkg, the unit and
// rau_fraction_checker, which predicts and compares every result.
module rational_arithmetic_unit_tb;
	import rau_pkg::*;

	localparam int RANDOM_ITEMS = 1000;
	localparam int PAUSE_EVERY = 150;
	localparam int DRAIN_CYCLES = 20;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	rau_in_t  operands;
	logic     done;
	rau_out_t result;
	int       mismatches;
	int       outstanding;
	int       no_gap_left = 0;

	rational_arithmetic_unit #(.VALUE_WIDTH(32)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.operands (operands),
		.done     (done),
		.result   (result)
	);

	rau_fraction_checker #(.VALUE_WIDTH(32)) scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operands    (operands),
		.done        (done),
		.result      (result),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Drop the run if the unit hangs; the slowest correct run needs about
	// a fifth of this.
	initial begin
		#15_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic rau_in_t fraction_pair(logic [1:0] func, logic [31:0] an,
		logic [31:0] ad, logic [31:0] bn, logic [31:0] bd);
		rau_in_t op;
		op.func = func;
		op.a_numerator = an;
		op.a_denominator = ad;
		op.b_numerator = bn;
		op.b_denominator = bd;
		return op;
	endfunction

	// Mix small values (rich common factors), full-width noise, the extremes
	// and scaled powers of two. Keep most denominators nonzero so the error
	// path stays a small share of the traffic.
	function automatic logic [31:0] draw_value(bit is_den);
		logic [31:0] v;
		int k;
		case ($urandom_range(0, 4))
			0, 1: v = 32'($urandom_range(0, 32)) - 32'd16;
			2: v = $urandom;
			3: begin
				case ($urandom_range(0, 5))
					0: v = 32'h8000_0000;
					1: v = 32'h7FFF_FFFF;
					2: v = 32'h8000_0001;
					3: v = 32'd1;
					4: v = 32'hFFFF_FFFF;
					default: v = 32'd0;
				endcase
			end
			default: begin
				k = $urandom_range(0, 30);
				v = (32'd1 << k) * 32'($urandom_range(1, 15));
				if ($urandom_range(0, 1))
					v = -v;
			end
		endcase
		if (is_den && v == 0 && $urandom_range(0, 7) != 0)
			v = 32'd1;
		return v;
	endfunction

	// Present one transaction and hold it until the unit takes it. Sometimes
	// wait for busy to fall first so the start lands at varied offsets from
	// the end of the previous transaction; now and then run a stretch with no
	// idling at all.
	task automatic send_fraction_pair(input rau_in_t op);
		int gap;
		bit settle;
		settle = 1'b0;
		if (no_gap_left > 0) begin
			gap = 0;
			no_gap_left--;
		end else begin
			gap = $urandom_range(0, 14);
			settle = $urandom_range(0, 1);
			if ($urandom_range(0, 19) == 0)
				no_gap_left = $urandom_range(5, 30);
		end
		if (gap > 0 || settle) begin
			start <= 1'b0;
			if (settle) begin
				do @(posedge clk); while (busy);
			end
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		operands <= op;
		do @(posedge clk); while (busy);
	endtask

	// Hold off until every predicted result has come back.
	task automatic drain_results;
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin
		rau_in_t directed[$];
		rau_in_t op;

		arst_n = 1'b0;
		start = 1'b0;
		operands = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed transactions: every operation, both error cases, the
		// overflow edges on numerator and denominator, zero results and the
		// extreme field values with both signs of denominator.
		directed.push_back(fraction_pair(FUNC_ADD, 1, 2, 1, 3));
		directed.push_back(fraction_pair(FUNC_SUB, 1, 2, 1, 2));
		directed.push_back(fraction_pair(FUNC_MUL, -2, 3, 3, -4));
		directed.push_back(fraction_pair(FUNC_DIV, 1, 2, -1, 4));
		directed.push_back(fraction_pair(FUNC_ADD, 1, 0, 1, 1));
		directed.push_back(fraction_pair(FUNC_MUL, 5, 7, 3, 0));
		directed.push_back(fraction_pair(FUNC_DIV, 1, 1, 0, 5));
		directed.push_back(fraction_pair(FUNC_DIV, 0, 0, 0, 0));
		directed.push_back(fraction_pair(FUNC_SUB, 3, 4, 0, 0));
		directed.push_back(fraction_pair(FUNC_ADD, 32'h7FFF_FFFF, 1, 1, 1));
		directed.push_back(fraction_pair(FUNC_SUB, 32'h8000_0000, 1, 1, 1));
		directed.push_back(fraction_pair(FUNC_MUL, 32'h8000_0000, 1, 1, 1));
		directed.push_back(fraction_pair(FUNC_MUL, 32'h8000_0000, 1, -1, 1));
		directed.push_back(fraction_pair(FUNC_DIV, 1, 32'h8000_0000, 1, 1));
		directed.push_back(fraction_pair(FUNC_DIV, 32'h8000_0000, 32'h8000_0000, 1, 1));
		directed.push_back(fraction_pair(FUNC_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000));
		directed.push_back(fraction_pair(FUNC_MUL, 32'h7FFF_FFFF, -1, 32'h7FFF_FFFF, 1));
		directed.push_back(fraction_pair(FUNC_ADD, 0, -5, 0, 7));
		directed.push_back(fraction_pair(FUNC_SUB, 3, -7, -3, 7));
		directed.push_back(fraction_pair(FUNC_DIV, -6, 4, -9, 6));
		directed.push_back(fraction_pair(FUNC_ADD, 1, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFE));
		directed.push_back(fraction_pair(FUNC_MUL, -1, -1, -1, -1));
		directed.push_back(fraction_pair(FUNC_SUB, 32'hAAAA_AAAA, 32'h5555_5555,
			32'h5555_5555, 32'hAAAA_AAAA));
		directed.push_back(fraction_pair(FUNC_DIV, 32'h8000_0000, 3, 32'h8000_0000, -3));
		foreach (directed[i])
			send_fraction_pair(directed[i]);
		drain_results();

		// Random transactions, with a full drain now and then.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			op.func = 2'($urandom_range(0, 3));
			op.a_numerator = draw_value(1'b0);
			op.a_denominator = draw_value(1'b1);
			op.b_numerator = draw_value(1'b0);
			op.b_denominator = draw_value(1'b1);
			send_fraction_pair(op);
			if (i % PAUSE_EVERY == PAUSE_EVERY - 1)
				drain_results();
		end

		// Wait out the tail, then let the unit settle before the verdict.
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

/* rational_arithmetic_unit.f */
rtl/core/rau_pkg.sv
rtl/core/rational_arithmetic_unit.sv
test/rau_fraction_checker.sv
test/rational_arithmetic_unit_tb.sv
